// ===== sv/mls_pkg.sv =====
`default_nettype none

package mls_pkg;

	// Fixed field widths of the configuration registers.
	localparam int GRID_W     = 9;
	localparam int ALPHA_W    = 32;
	localparam int SCALE_W    = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// Fraction bits dropped when the edge and outside products are rounded.
	localparam int EDGE_FRAC  = 16;
	localparam int SCALE_FRAC = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLS     = 3'd0,
		REG_GRID_ROWS     = 3'd1,
		REG_ALPHA_LEFT    = 3'd2,
		REG_ALPHA_RIGHT   = 3'd3,
		REG_ALPHA_BOTTOM  = 3'd4,
		REG_ALPHA_TOP     = 3'd5,
		REG_OUTSIDE_SCALE = 3'd6
	} cfg_reg_t;

	localparam logic ACT_CELL  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// What the sequencer decides for one accepted request.
	typedef struct packed {
		logic emit;
		logic write;
		logic last;
		logic has_up;
		logic has_down;
		logic has_left;
		logic has_right;
		logic edge_left;
		logic edge_right;
		logic edge_bottom;
		logic edge_top;
	} event_t;

endpackage

`default_nettype wire

// ===== sv/mls_if.sv =====
`default_nettype none

interface mls_cell_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [VALUE_BITS-1:0] cell_value;
	logic                  inside_req;

	modport source (output valid, action, cell_value, inside_req, input ready);
	modport sink (input valid, action, cell_value, inside_req, output ready);
endinterface

interface mls_result_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] result_value;
	logic                  last_cell;

	modport source (output valid, result_value, last_cell, input ready);
	modport sink (input valid, result_value, last_cell, output ready);
endinterface

`default_nettype wire

// ===== sv/mls_seq.sv =====
`default_nettype none

// Raster position counters. Decides, for each accepted request, whether the
// cell is stored, whether a result is due and where that result lies.
module mls_seq #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256,
	localparam int CIW = $clog2(MAX_COLS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       action,
	input  logic [mls_pkg::GRID_W-1:0] grid_cols,
	input  logic [mls_pkg::GRID_W-1:0] grid_rows,
	output mls_pkg::event_t            ev,
	output logic [CIW-1:0]             wr_col,
	output logic [CIW-1:0]             a_col,
	output logic [CIW-1:0]             b_col
);

	localparam int CW   = $clog2(MAX_COLS + 1);
	localparam int RW   = $clog2(MAX_ROWS + 1);
	localparam int POSW = $clog2(MAX_COLS * MAX_ROWS + 1);

	logic [CW-1:0]   cols_use;
	logic [RW-1:0]   rows_use;
	logic [POSW-1:0] total;

	logic [POSW-1:0] in_pos_q;
	logic [POSW-1:0] out_pos_q;
	logic [CIW-1:0]  in_col_q;
	logic [CIW-1:0]  out_col_q;
	logic [RW-1:0]   out_row_q;

	logic          is_cell;
	logic          is_drain;
	logic          in_full;
	logic          out_done;
	logic          emit_cell;
	logic          emit_drain;
	logic          flush;
	logic          last;
	logic [CW:0]   in_col_next;
	logic [CW:0]   out_col_next;
	logic [RW:0]   out_row_next;

	always_comb begin
		if (grid_cols == '0) begin
			cols_use = CW'(1);
		end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
			cols_use = CW'(MAX_COLS);
		end else begin
			cols_use = CW'(grid_cols);
		end
		if (grid_rows == '0) begin
			rows_use = RW'(1);
		end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
			rows_use = RW'(MAX_ROWS);
		end else begin
			rows_use = RW'(grid_rows);
		end
	end

	assign total = POSW'(POSW'(cols_use) * POSW'(rows_use));

	assign is_cell    = (action == mls_pkg::ACT_CELL);
	assign is_drain   = (action == mls_pkg::ACT_DRAIN);
	assign in_full    = (in_pos_q >= total);
	assign out_done   = (out_pos_q >= total);
	assign emit_cell  = is_cell && !in_full && (in_pos_q >= POSW'(cols_use)) && !out_done;
	assign emit_drain = is_drain && in_full && !out_done;
	assign flush      = is_drain && in_full && out_done;
	assign last       = (({1'b0, out_pos_q} + (POSW+1)'(1)) >= {1'b0, total});

	assign in_col_next  = (CW+1)'(in_col_q) + (CW+1)'(1);
	assign out_col_next = (CW+1)'(out_col_q) + (CW+1)'(1);
	assign out_row_next = (RW+1)'(out_row_q) + (RW+1)'(1);

	always_comb begin
		ev.emit        = emit_cell || emit_drain;
		ev.write       = is_cell && !in_full;
		ev.last        = last;
		ev.has_up      = emit_cell && (out_row_next < (RW+1)'(rows_use));
		ev.has_down    = (out_row_q != '0);
		ev.has_left    = (out_col_q != '0);
		ev.has_right   = (out_col_next < (CW+1)'(cols_use));
		ev.edge_left   = (out_col_q == '0);
		ev.edge_right  = (out_col_next == (CW+1)'(cols_use));
		ev.edge_bottom = (out_row_q == '0);
		ev.edge_top    = (out_row_next == (RW+1)'(rows_use));
	end

	assign wr_col = in_col_q;
	assign a_col  = is_cell ? in_col_q : out_col_q;
	assign b_col  = out_col_q + CIW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q  <= '0;
			out_pos_q <= '0;
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (ev.write) begin
				in_pos_q <= in_pos_q + POSW'(1);
				if (in_col_next >= (CW+1)'(cols_use)) begin
					in_col_q <= '0;
				end else begin
					in_col_q <= in_col_q + CIW'(1);
				end
			end
			if (ev.emit) begin
				if (last) begin
					in_pos_q  <= '0;
					out_pos_q <= '0;
					in_col_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					out_pos_q <= out_pos_q + POSW'(1);
					if (out_col_next >= (CW+1)'(cols_use)) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CIW'(1);
					end
				end
			end
			if (flush) begin
				in_pos_q  <= '0;
				out_pos_q <= '0;
				in_col_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mls_window.sv =====
`default_nettype none

// Two-row line window held per column: each word keeps the newest and the
// second newest cell of its column. One write port, two registered read ports.
// A word written in the cycle after its read is forwarded to a read of the
// same column in that cycle.
module mls_window #(
	parameter int MAX_COLS = 256,
	parameter int VALUE_BITS = 32,
	localparam int CIW = $clog2(MAX_COLS),
	localparam int DW = VALUE_BITS + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           wr_en,
	input  logic [CIW-1:0] wr_col,
	input  logic [DW-1:0]  wr_data,
	input  logic [CIW-1:0] a_col,
	input  logic [CIW-1:0] b_col,
	output logic [DW-1:0]  a_r1,
	output logic [DW-1:0]  a_r2,
	output logic [DW-1:0]  b_r1
);

	logic [2*DW-1:0] mem [MAX_COLS];
	logic [2*DW-1:0] a_q;
	logic [DW-1:0]   b_q;
	logic            wr_pend_s1;
	logic [CIW-1:0]  wr_col_s1;
	logic [DW-1:0]   wr_data_s1;
	logic [2*DW-1:0] fwd;
	logic            a_hit;
	logic            b_hit;

	// The new cell becomes the newest entry, the old newest moves down.
	assign fwd   = {wr_data_s1, a_q[2*DW-1:DW]};
	assign a_hit = wr_pend_s1 && (wr_col_s1 == a_col);
	assign b_hit = wr_pend_s1 && (wr_col_s1 == b_col);

	always_ff @(posedge clk) begin
		if (wr_pend_s1) begin
			mem[wr_col_s1] <= fwd;
		end
		if (accept) begin
			a_q        <= a_hit ? fwd : mem[a_col];
			b_q        <= b_hit ? wr_data_s1 : mem[b_col][2*DW-1:DW];
			wr_col_s1  <= wr_col;
			wr_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= accept && wr_en;
		end
	end

	assign a_r1 = a_q[2*DW-1:DW];
	assign a_r2 = a_q[DW-1:0];
	assign b_r1 = b_q;

endmodule

`default_nettype wire

// ===== sv/mls_core.sv =====
`default_nettype none

// Arithmetic pipeline: neighbour sum and products, then rounding, summing and
// saturation into the output register.
module mls_core #(
	parameter int VALUE_BITS = 32,
	localparam int DW = VALUE_BITS + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  mls_pkg::event_t             ev,
	input  logic [DW-1:0]               up_data,
	input  logic [DW-1:0]               a_r1,
	input  logic [DW-1:0]               a_r2,
	input  logic [DW-1:0]               b_r1,
	input  logic [mls_pkg::ALPHA_W-1:0] alpha_left,
	input  logic [mls_pkg::ALPHA_W-1:0] alpha_right,
	input  logic [mls_pkg::ALPHA_W-1:0] alpha_bottom,
	input  logic [mls_pkg::ALPHA_W-1:0] alpha_top,
	input  logic [mls_pkg::SCALE_W-1:0] outside_scale,
	input  logic                        out_ready,
	output logic                        in_ready,
	output logic                        out_valid,
	output logic [VALUE_BITS-1:0]       result_value,
	output logic                        last_cell
);

	localparam int VB    = VALUE_BITS;
	localparam int ACC_W = VALUE_BITS + 18;
	localparam int PRW   = VALUE_BITS + mls_pkg::ALPHA_W;
	localparam int POW   = VALUE_BITS + mls_pkg::SCALE_W + 1;

	localparam logic signed [PRW:0] RND_E =
		{{(PRW + 1 - mls_pkg::EDGE_FRAC){1'b0}}, 1'b1, {(mls_pkg::EDGE_FRAC - 1){1'b0}}};
	localparam logic signed [POW:0] RND_S =
		{{(POW + 1 - mls_pkg::SCALE_FRAC){1'b0}}, 1'b1, {(mls_pkg::SCALE_FRAC - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W - VB + 1){1'b1}}, {(VB - 1){1'b0}}};

	function automatic logic signed [ACC_W-1:0] edge_round(input logic signed [PRW-1:0] p);
		logic signed [PRW:0] t;
		t = (PRW+1)'(p) + RND_E;
		return ACC_W'(t >>> mls_pkg::EDGE_FRAC);
	endfunction

	function automatic logic signed [ACC_W-1:0] scale_round(input logic signed [POW-1:0] p);
		logic signed [POW:0] t;
		t = (POW+1)'(p) + RND_S;
		return ACC_W'(t >>> mls_pkg::SCALE_FRAC);
	endfunction

	// Stage one: event and the cell above, aligned with the window read data.
	logic            valid_s1;
	mls_pkg::event_t ev_s1;
	logic [DW-1:0]   up_s1;
	logic [DW-1:0]   left_q;

	// Stage two: neighbour sum and raw products.
	logic                    valid_s2;
	logic                    inside_s2;
	logic                    last_s2;
	logic signed [ACC_W-1:0] nsum_s2;
	logic signed [PRW-1:0]   prod_l_s2;
	logic signed [PRW-1:0]   prod_r_s2;
	logic signed [PRW-1:0]   prod_b_s2;
	logic signed [PRW-1:0]   prod_t_s2;
	logic signed [POW-1:0]   prod_o_s2;

	// Output register.
	logic                  out_valid_q;
	logic [VB-1:0]         result_q;
	logic                  last_q;

	logic s2_free;
	logic s3_free;

	logic signed [VB-1:0]      v;
	logic signed [VB-1:0]      up_v;
	logic signed [VB-1:0]      down_v;
	logic signed [VB-1:0]      left_v;
	logic signed [VB-1:0]      right_v;
	logic signed [ACC_W-1:0]   nsum_d;
	logic signed [mls_pkg::ALPHA_W-1:0] al_l;
	logic signed [mls_pkg::ALPHA_W-1:0] al_r;
	logic signed [mls_pkg::ALPHA_W-1:0] al_b;
	logic signed [mls_pkg::ALPHA_W-1:0] al_t;
	logic signed [mls_pkg::SCALE_W:0]   scale_s;
	logic signed [ACC_W-1:0]   acc_d;
	logic [VB-1:0]             sat_d;

	assign s3_free  = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || s3_free;
	assign in_ready = !valid_s1 || s2_free;

	always_comb begin
		v       = $signed(a_r1[VB-1:0]);
		up_v    = (ev_s1.has_up && up_s1[DW-1]) ? $signed(up_s1[VB-1:0]) : '0;
		down_v  = (ev_s1.has_down && a_r2[DW-1]) ? $signed(a_r2[VB-1:0]) : '0;
		left_v  = (ev_s1.has_left && left_q[DW-1]) ? $signed(left_q[VB-1:0]) : '0;
		right_v = (ev_s1.has_right && b_r1[DW-1]) ? $signed(b_r1[VB-1:0]) : '0;
		nsum_d  = (ACC_W'(v) <<< 2) - ACC_W'(up_v) - ACC_W'(down_v)
			- ACC_W'(left_v) - ACC_W'(right_v);
		// A zero coefficient gives a zero term after rounding.
		al_l    = ev_s1.edge_left ? $signed(alpha_left) : '0;
		al_r    = ev_s1.edge_right ? $signed(alpha_right) : '0;
		al_b    = ev_s1.edge_bottom ? $signed(alpha_bottom) : '0;
		al_t    = ev_s1.edge_top ? $signed(alpha_top) : '0;
		scale_s = $signed({1'b0, outside_scale});
	end

	always_comb begin
		if (inside_s2) begin
			acc_d = nsum_s2 - edge_round(prod_l_s2) - edge_round(prod_r_s2)
				- edge_round(prod_b_s2) - edge_round(prod_t_s2);
		end else begin
			acc_d = scale_round(prod_o_s2);
		end
		if (acc_d > SAT_HI) begin
			sat_d = SAT_HI[VB-1:0];
		end else if (acc_d < SAT_LO) begin
			sat_d = SAT_LO[VB-1:0];
		end else begin
			sat_d = acc_d[VB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= accept && ev.emit;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s3_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= ev;
			up_s1 <= up_data;
		end
		if (valid_s1 && s2_free) begin
			// The centre of this result is the left neighbour of the next one.
			left_q    <= a_r1;
			inside_s2 <= a_r1[DW-1];
			last_s2   <= ev_s1.last;
			nsum_s2   <= nsum_d;
			prod_l_s2 <= al_l * v;
			prod_r_s2 <= al_r * v;
			prod_b_s2 <= al_b * v;
			prod_t_s2 <= al_t * v;
			prod_o_s2 <= scale_s * v;
		end
		if (valid_s2 && s3_free) begin
			result_q <= sat_d;
			last_q   <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign last_cell    = last_q;

endmodule

`default_nettype wire

// ===== sv/masked_laplacian_stencil_unit.sv =====
`default_nettype none

// Masked five-point Laplacian over a grid streamed in raster order (row 0
// first, column 0 first in each row). Each request carries a signed Q16.16
// cell value and an inside bit; an inside cell yields four times its value
// minus each inside neighbour within the grid, less the rounded alpha term of
// every grid edge it lies on, and an outside cell yields its value times
// outside_scale; results saturate to VALUE_BITS signed bits. The result for a
// cell is computed once the cell directly above it has arrived, so results
// lag the input by one grid row: after the last cell of a grid, send one drain
// request per cell of the last row to flush it, and the result carrying
// last_cell closes the grid. Cell requests beyond a complete grid and drains
// before it is complete are taken and dropped. One request is accepted every
// clock cycle, stalled only when the output side is full; a result is
// registered in turn by the window read, the multiplier stage and the output
// register after the request that releases it. The line window is a memory of
// MAX_COLS words, each holding the two newest cells of one column, with one
// write port and two read ports; it needs no clearing after reset. Write
// grid_cols and grid_rows only between grids.
module masked_laplacian_stencil_unit #(
	parameter int MAX_COLS   = 256,
	parameter int MAX_ROWS   = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mls_cell_if.sink                       cells,
	mls_result_if.source                   results,
	input  logic                           cfg_write,
	input  logic [mls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mls_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CIW = $clog2(MAX_COLS);
	localparam int DW  = VALUE_BITS + 1;

	// Configuration registers, reset to a 256-column, 256-row grid with no edge terms.
	logic [mls_pkg::GRID_W-1:0]  grid_cols_q;
	logic [mls_pkg::GRID_W-1:0]  grid_rows_q;
	logic [mls_pkg::ALPHA_W-1:0] alpha_left_q;
	logic [mls_pkg::ALPHA_W-1:0] alpha_right_q;
	logic [mls_pkg::ALPHA_W-1:0] alpha_bottom_q;
	logic [mls_pkg::ALPHA_W-1:0] alpha_top_q;
	logic [mls_pkg::SCALE_W-1:0] outside_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q     <= mls_pkg::GRID_W'(256);
			grid_rows_q     <= mls_pkg::GRID_W'(256);
			alpha_left_q    <= '0;
			alpha_right_q   <= '0;
			alpha_bottom_q  <= '0;
			alpha_top_q     <= '0;
			outside_scale_q <= '0;
		end else if (cfg_write) begin
			case (mls_pkg::cfg_reg_t'(cfg_index))
				mls_pkg::REG_GRID_COLS: begin
					grid_cols_q <= cfg_data[mls_pkg::GRID_W-1:0];
				end
				mls_pkg::REG_GRID_ROWS: begin
					grid_rows_q <= cfg_data[mls_pkg::GRID_W-1:0];
				end
				mls_pkg::REG_ALPHA_LEFT: begin
					alpha_left_q <= cfg_data[mls_pkg::ALPHA_W-1:0];
				end
				mls_pkg::REG_ALPHA_RIGHT: begin
					alpha_right_q <= cfg_data[mls_pkg::ALPHA_W-1:0];
				end
				mls_pkg::REG_ALPHA_BOTTOM: begin
					alpha_bottom_q <= cfg_data[mls_pkg::ALPHA_W-1:0];
				end
				mls_pkg::REG_ALPHA_TOP: begin
					alpha_top_q <= cfg_data[mls_pkg::ALPHA_W-1:0];
				end
				mls_pkg::REG_OUTSIDE_SCALE: begin
					outside_scale_q <= cfg_data[mls_pkg::SCALE_W-1:0];
				end
				default: begin
					// Writes to unused indices are dropped.
				end
			endcase
		end
	end

	logic            accept;
	logic            in_ready;
	mls_pkg::event_t ev;
	logic [CIW-1:0]  wr_col;
	logic [CIW-1:0]  a_col;
	logic [CIW-1:0]  b_col;
	logic [DW-1:0]   cell_data;
	logic [DW-1:0]   a_r1;
	logic [DW-1:0]   a_r2;
	logic [DW-1:0]   b_r1;

	// A request is taken whenever the first pipeline stage can move on.
	assign cells.ready = in_ready;
	assign accept      = cells.valid && in_ready;
	assign cell_data   = {cells.inside_req, cells.cell_value};

	// Position counters decide what each request does.
	mls_seq #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (cells.action),
		.grid_cols (grid_cols_q),
		.grid_rows (grid_rows_q),
		.ev        (ev),
		.wr_col    (wr_col),
		.a_col     (a_col),
		.b_col     (b_col)
	);

	// Column-organised two-row window: port A gives the centre and the cell
	// below it, port B the cell to the right of the centre.
	mls_window #(
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.wr_en   (ev.write),
		.wr_col  (wr_col),
		.wr_data (cell_data),
		.a_col   (a_col),
		.b_col   (b_col),
		.a_r1    (a_r1),
		.a_r2    (a_r2),
		.b_r1    (b_r1)
	);

	// The incoming cell is the neighbour above the centre.
	mls_core #(
		.VALUE_BITS (VALUE_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.ev            (ev),
		.up_data       (cell_data),
		.a_r1          (a_r1),
		.a_r2          (a_r2),
		.b_r1          (b_r1),
		.alpha_left    (alpha_left_q),
		.alpha_right   (alpha_right_q),
		.alpha_bottom  (alpha_bottom_q),
		.alpha_top     (alpha_top_q),
		.outside_scale (outside_scale_q),
		.out_ready     (results.ready),
		.in_ready      (in_ready),
		.out_valid     (results.valid),
		.result_value  (results.result_value),
		.last_cell     (results.last_cell)
	);

endmodule

`default_nettype wire
